### sv/msp_pkg.sv
// Shared types and constants for the matrix scale, sum and product unit.
// No dependencies; used by the top-level module of the block.
package msp_pkg;

  // Default storage geometry
  localparam int DIM_MAX_DEFAULT    = 16;
  localparam int ELEM_WIDTH_DEFAULT = 16;

  // Configuration register widths and reset values
  localparam int SIZE_W     = 5;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(16);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_P     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q     = 2'd2;

  // Input item fields
  localparam int OPCODE_W = 1;
  localparam int INDEX_W  = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 1'b0,
    OP_PRODUCT = 1'b1
  } op_t;

  // Result item fields
  localparam int STATUS_W  = 1;
  localparam int SCALED_W  = 34;
  localparam int PRODUCT_W = 40;
  localparam int OUT_BITS  = STATUS_W + 2 * SCALED_W + PRODUCT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 1'b1;

endpackage

### sv/msp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; holds the matrix element stores.
module msp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data is registered and appears in the cycle after the address; a read of the entry
  // written in the same cycle returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/matrix_scale_sum_and_product_unit.sv
// Matrix scale, sum and product unit, top level.
// Depends on msp_pkg and msp_ram (stores for A and for A+B).
//
// One request is handled at a time. A load or an out-of-range request goes
// from acceptance straight to the finish state; a product read first walks
// the inner index over the n elements of the effective matrix size, one
// element a cycle, with a single multiply-accumulate reading
// (A+B)[row][k] and A[k][col] from the two element memories. A new request
// is accepted once the result has moved into the output register. Elements
// are stored at row*DIM_MAX+col; product reads must only touch loaded
// positions. A size above DIM_MAX acts as DIM_MAX, a size of zero rejects
// every request with status 1.
module matrix_scale_sum_and_product_unit
  import msp_pkg::*;
#(
  parameter int DIM_MAX    = DIM_MAX_DEFAULT,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Request stream
  input  logic s_tvalid,
  output logic s_tready,
  // s_tdata: opcode, row_index, col_index, a_value, b_value (lowest bit first)
  input  logic [((OPCODE_W + 2 * INDEX_W + 2 * ELEM_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // Result stream
  output logic m_tvalid,
  input  logic m_tready,
  // m_tdata: status, scaled_difference, scaled_combination, product_value
  output logic [OUT_W-1:0] m_tdata
);

  localparam int DEPTH   = DIM_MAX * DIM_MAX;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DIM_MAX + 1);
  localparam int NW      = (SIZE_W > CNT_W) ? SIZE_W : CNT_W;
  localparam int SUM_W   = ELEM_WIDTH + 1;
  localparam int SPW     = SCALE_W + ELEM_WIDTH;
  localparam int SXW     = (SPW > SCALED_W) ? SPW : SCALED_W;
  localparam int MPW     = SUM_W + ELEM_WIDTH;
  localparam int MXW     = (MPW > PRODUCT_W) ? MPW : PRODUCT_W;
  localparam int A_LSB   = OPCODE_W + 2 * INDEX_W;
  localparam int B_LSB   = A_LSB + ELEM_WIDTH;
  localparam int PAD_W   = OUT_W - OUT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic        [SIZE_W-1:0]  matrix_size;
  logic signed [SCALE_W-1:0] scale_p;
  logic signed [SCALE_W-1:0] scale_q;

  // Request fields
  op_t                          in_op;
  logic        [INDEX_W-1:0]    in_row;
  logic        [INDEX_W-1:0]    in_col;
  logic signed [ELEM_WIDTH-1:0] in_a;
  logic signed [ELEM_WIDTH-1:0] in_b;
  logic                         in_fire;
  logic                         in_err;
  logic        [NW-1:0]         n_eff;

  // Load arithmetic
  logic signed [SPW-1:0]      mul_pa, mul_qb, mul_pb, mul_qa;
  logic signed [SXW-1:0]      ext_pa, ext_qb, ext_pb, ext_qa;
  logic signed [SCALED_W-1:0] pa, qb, pb, qa;
  logic signed [SCALED_W-1:0] diff_res, comb_res;

  // Item bookkeeping
  op_t  item_op;
  logic item_err;

  // Memory ports
  logic                         mem_we;
  logic        [ADDR_W-1:0]     waddr;
  logic        [SUM_W-1:0]      sum_wdata;
  logic        [ADDR_W-1:0]     sum_addr;
  logic        [ADDR_W-1:0]     a_addr;
  logic signed [SUM_W-1:0]      sum_q;
  logic signed [ELEM_WIDTH-1:0] a_q;

  // Product walk
  logic        [NW-1:0]        k;
  logic                        issue;
  logic                        rd_v;
  logic                        mac_v;
  logic signed [MPW-1:0]       mac_mul;
  logic signed [MXW-1:0]       mac_ext;
  logic signed [PRODUCT_W-1:0] mac_prod;
  logic signed [PRODUCT_W-1:0] acc;
  logic                        walk_done;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
      scale_p     <= SCALE_RESET;
      scale_q     <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MATRIX_SIZE: matrix_size <= cfg_wdata[SIZE_W-1:0];
        REG_SCALE_P:     scale_p     <= cfg_wdata[SCALE_W-1:0];
        REG_SCALE_Q:     scale_q     <= cfg_wdata[SCALE_W-1:0];
        default:         ;
      endcase
    end
  end

  // Unpack the request and check the range
  assign in_op   = op_t'(s_tdata[OPCODE_W-1:0]);
  assign in_row  = s_tdata[OPCODE_W +: INDEX_W];
  assign in_col  = s_tdata[OPCODE_W + INDEX_W +: INDEX_W];
  assign in_a    = s_tdata[A_LSB +: ELEM_WIDTH];
  assign in_b    = s_tdata[B_LSB +: ELEM_WIDTH];
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  assign n_eff  = (NW'(matrix_size) > NW'(DIM_MAX)) ? NW'(DIM_MAX) : NW'(matrix_size);
  assign in_err = (NW'(in_row) >= n_eff) || (NW'(in_col) >= n_eff);

  // Scale products, all taken modulo the result width
  assign mul_pa = scale_p * in_a;
  assign mul_qb = scale_q * in_b;
  assign mul_pb = scale_p * in_b;
  assign mul_qa = scale_q * in_a;
  assign ext_pa = SXW'(mul_pa);
  assign ext_qb = SXW'(mul_qb);
  assign ext_pb = SXW'(mul_pb);
  assign ext_qa = SXW'(mul_qa);

  assign diff_res = pa - qb;
  assign comb_res = (pb <<< 1) - qa;

  // Store writes on a good load
  assign mem_we    = in_fire && (in_op == OP_LOAD) && !in_err;
  assign waddr     = ADDR_W'(in_row * DIM_MAX + in_col);
  assign sum_wdata = SUM_W'(in_a) + SUM_W'(in_b);

  msp_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (in_a),
    .raddr (a_addr),
    .rdata (a_q)
  );

  msp_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_sum_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (sum_wdata),
    .raddr (sum_addr),
    .rdata (sum_q)
  );

  // Multiply-accumulate on the registered memory outputs
  assign issue     = (state == ST_RUN) && (k < n_eff);
  assign mac_mul   = sum_q * a_q;
  assign mac_ext   = MXW'(mac_mul);
  assign walk_done = (state == ST_RUN) && !issue && !rd_v && !mac_v;

  // Advance the product walk pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v  <= 1'b0;
      mac_v <= 1'b0;
    end else begin
      rd_v  <= issue;
      mac_v <= rd_v;
    end
  end

  // Capture load products, walk addresses and the accumulator
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op  <= in_op;
      item_err <= in_err;
      pa       <= ext_pa[SCALED_W-1:0];
      qb       <= ext_qb[SCALED_W-1:0];
      pb       <= ext_pb[SCALED_W-1:0];
      qa       <= ext_qa[SCALED_W-1:0];
      sum_addr <= ADDR_W'(in_row * DIM_MAX);
      a_addr   <= ADDR_W'(in_col);
      k        <= '0;
      acc      <= '0;
    end else begin
      if (issue) begin
        sum_addr <= sum_addr + ADDR_W'(1);
        a_addr   <= a_addr + ADDR_W'(DIM_MAX);
        k        <= k + NW'(1);
      end
      if (mac_v) begin
        acc <= acc + mac_prod;
      end
    end
    if (rd_v) begin
      mac_prod <= mac_ext[PRODUCT_W-1:0];
    end
  end

  // Sequence the request and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // Drop valid once the result is taken, unless a new one replaces it
      if (m_tvalid && m_tready && state != ST_FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_op == OP_PRODUCT && !in_err) begin
              state <= ST_RUN;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_RUN: begin
          if (walk_done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            if (item_err) begin
              m_tdata <= {PAD_W'(0), PRODUCT_W'(0), SCALED_W'(0), SCALED_W'(0), STATUS_RANGE};
            end else if (item_op == OP_LOAD) begin
              m_tdata <= {PAD_W'(0), PRODUCT_W'(0), comb_res, diff_res, STATUS_OK};
            end else begin
              m_tdata <= {PAD_W'(0), acc, SCALED_W'(0), SCALED_W'(0), STATUS_OK};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The inner index never runs past the effective size
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (k <= n_eff))
    else $error("inner index beyond matrix size");

  // A good product read starts the walk on the next cycle
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_op == OP_PRODUCT && !in_err) |=> (state == ST_RUN && k == '0))
    else $error("product walk did not start");

  // The result is only formed after the walk pipeline has drained
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (!rd_v && !mac_v))
    else $error("result formed with accumulations in flight");

  // A new result only appears out of the finish state
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FIN))
    else $error("result valid raised outside finish state");

endmodule
